// File: rtl/core/midpoint_ellipse_rasterizer_core_assert.svh
// Assertion macros shared by the ellipse rasterizer RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication
`define MER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mer_pkg.sv
package mer_pkg;

    // Fixed field widths
    localparam int IN_W           = 10;
    localparam int PIX_W          = 12;
    localparam int MER_COORD_BITS = 10;
    localparam int UPC_W          = 4;

    // Mirror quadrant codes: bit 1 negates x, bit 0 negates y
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_PM = 2'd1;
    localparam logic [1:0] QUAD_MP = 2'd2;
    localparam logic [1:0] QUAD_MM = 2'd3;

    // Microprogram addresses
    localparam logic [UPC_W-1:0] PC_ST0 = 4'd0;
    localparam logic [UPC_W-1:0] PC_ST1 = 4'd1;
    localparam logic [UPC_W-1:0] PC_ST2 = 4'd2;
    localparam logic [UPC_W-1:0] PC_ST3 = 4'd3;
    localparam logic [UPC_W-1:0] PC_ST4 = 4'd4;
    localparam logic [UPC_W-1:0] PC_SP0 = 4'd5;
    localparam logic [UPC_W-1:0] PC_SP1 = 4'd6;
    localparam logic [UPC_W-1:0] PC_SP2 = 4'd7;
    localparam logic [UPC_W-1:0] PC_SP3 = 4'd8;
    localparam logic [UPC_W-1:0] PC_R0  = 4'd9;
    localparam logic [UPC_W-1:0] PC_R1  = 4'd10;
    localparam logic [UPC_W-1:0] PC_R2  = 4'd11;
    localparam logic [UPC_W-1:0] PC_R3  = 4'd12;
    localparam logic [UPC_W-1:0] PC_R4  = 4'd13;
    localparam logic [UPC_W-1:0] PC_R5  = 4'd14;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        MS_ZERO   = 3'd0,
        MS_SEMI_A = 3'd1,
        MS_SEMI_B = 3'd2,
        MS_AA     = 3'd3,
        MS_BB     = 3'd4,
        MS_TX     = 3'd5,
        MS_TY     = 3'd6,
        MS_PROD   = 3'd7
    } mul_sel_t;

    // Decision register operations
    typedef enum logic [2:0] {
        DEC_HOLD = 3'd0,
        DEC_INIT = 3'd1,
        DEC_STEP = 3'd2,
        DEC_LOAD = 3'd3,
        DEC_ADD4 = 3'd4,
        DEC_SUB4 = 3'd5
    } dec_op_t;

    // Sequencer flow
    typedef enum logic [1:0] {
        JMP_NEXT  = 2'd0,
        JMP_END   = 2'd1,
        JMP_CROSS = 2'd2
    } jmp_t;

    // One control word
    typedef struct packed {
        mul_sel_t   mul_a;
        mul_sel_t   mul_b;
        logic       ld_aa;
        logic       ld_bb;
        logic       ld_sy;
        dec_op_t    dec_op;
        logic       pt_adv;
        logic       emit;
        logic [1:0] quad;
        logic       set_r2;
        jmp_t       jmp;
    } cw_t;

    // Request payload
    typedef struct packed {
        logic            action;
        logic [IN_W-1:0] center_x;
        logic [IN_W-1:0] center_y;
        logic [IN_W-1:0] radius_x;
        logic [IN_W-1:0] radius_y;
    } req_t;

    // Result payload
    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    last_of_step;
        logic                    ellipse_done;
    } pix_t;

    // Microprogram ROM
    function automatic cw_t ucode_word(input logic [UPC_W-1:0] pc);
        cw_t w;
        w = '0;
        case (pc)
            // start: a*a, b*b, a*a*b, initial decision, region check
            PC_ST0:
            begin
                w.mul_a = MS_SEMI_A;
                w.mul_b = MS_SEMI_A;
            end
            PC_ST1:
            begin
                w.ld_aa = 1'b1;
                w.mul_a = MS_SEMI_B;
                w.mul_b = MS_SEMI_B;
            end
            PC_ST2:
            begin
                w.ld_bb = 1'b1;
                w.mul_a = MS_AA;
                w.mul_b = MS_SEMI_B;
            end
            PC_ST3:
            begin
                w.ld_sy  = 1'b1;
                w.dec_op = DEC_INIT;
            end
            PC_ST4:
            begin
                w.jmp = JMP_CROSS;
            end
            // step: four mirrored pixels while the point advances
            PC_SP0:
            begin
                w.pt_adv = 1'b1;
                w.emit   = 1'b1;
                w.quad   = QUAD_PP;
            end
            PC_SP1:
            begin
                w.dec_op = DEC_STEP;
                w.emit   = 1'b1;
                w.quad   = QUAD_PM;
            end
            PC_SP2:
            begin
                w.emit = 1'b1;
                w.quad = QUAD_MP;
            end
            PC_SP3:
            begin
                w.emit = 1'b1;
                w.quad = QUAD_MM;
                w.jmp  = JMP_CROSS;
            end
            // region two entry: bb*tx^2 + 4*aa*ty^2 - 4*aa*bb
            PC_R0:
            begin
                w.mul_a = MS_TX;
                w.mul_b = MS_TX;
            end
            PC_R1:
            begin
                w.mul_a = MS_BB;
                w.mul_b = MS_PROD;
            end
            PC_R2:
            begin
                w.dec_op = DEC_LOAD;
                w.mul_a  = MS_TY;
                w.mul_b  = MS_TY;
            end
            PC_R3:
            begin
                w.mul_a = MS_AA;
                w.mul_b = MS_PROD;
            end
            PC_R4:
            begin
                w.dec_op = DEC_ADD4;
                w.mul_a  = MS_AA;
                w.mul_b  = MS_BB;
            end
            PC_R5:
            begin
                w.dec_op = DEC_SUB4;
                w.set_r2 = 1'b1;
                w.jmp    = JMP_END;
            end
            default:
            begin
                w.jmp = JMP_END;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/mer_useq.sv
module mer_useq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      launch,
    input  logic [mer_pkg::UPC_W-1:0] launch_pc,
    input  logic                      enter_r2,
    output logic                      busy,
    output mer_pkg::cw_t              cw
);
    import mer_pkg::*;

    logic             active_reg;
    logic             active_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    // Control word of the current step, idle word when stopped
    always_comb
    begin
        cw = active_reg ? ucode_word(upc_reg) : '0;
    end

    // Step counter and jumps
    always_comb
    begin
        active_next = active_reg;
        upc_next    = upc_reg;
        if (launch)
        begin
            active_next = 1'b1;
            upc_next    = launch_pc;
        end
        else if (active_reg)
        begin
            case (cw.jmp)
                JMP_NEXT:
                begin
                    upc_next = UPC_W'(upc_reg + 1'b1);
                end
                JMP_END:
                begin
                    active_next = 1'b0;
                end
                JMP_CROSS:
                begin
                    if (enter_r2)
                    begin
                        upc_next = PC_R0;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    active_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            upc_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            upc_reg    <= upc_next;
        end
    end

    assign busy = active_reg;

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer_core.sv
// Midpoint ellipse rasterizer.
// Request channel: start with req; a request is taken on a clock edge where
// start is high and busy is low. action 0 loads centre and radii and puts
// the point at (0, b); action 1 plots the current point and advances it.
// Result channel: result_valid marks one pixel for one cycle; a step gives
// four pixels on consecutive cycles (x+,y+ / x+,y- / x-,y+ / x-,y-), the
// fourth with last_of_step, and ellipse_done on the fourth once y < 0.
// A step keeps busy high through its pixel words, and a start through its
// start words; either also runs the region-two entry words when it enters
// region two. The first pixel goes through the sequencer's step register
// and then the output register. This follows from the microprogram: one
// control word per cycle, one shared multiplier with a registered product.
// A step before any start or after completion is taken and ignored.
// Reset stops the sequencer and leaves the block idle with no ellipse.
// The receiver cannot stall: pixels leave at one per cycle.
`include "midpoint_ellipse_rasterizer_core_assert.svh"

module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS = mer_pkg::MER_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mer_pkg::req_t req,
    output logic          busy,
    output logic          result_valid,
    output mer_pkg::pix_t result
);
    import mer_pkg::*;

    localparam int CW = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
    localparam int XW = CW + 1;
    localparam int YW = CW + 2;
    localparam int AW = 2 * CW;
    localparam int MW = 2 * CW + 4;
    localparam int PW = 2 * MW;
    localparam int SW = 3 * CW + 3;
    localparam int DW = 4 * CW + 8;

    // Sequencer hookup
    cw_t              ctl;
    logic             launch;
    logic             launch_start;
    logic [UPC_W-1:0] launch_pc;
    logic             enter_r2;

    // Ellipse and point state
    logic [CW-1:0]        ctr_x_reg;
    logic [CW-1:0]        ctr_y_reg;
    logic [CW-1:0]        semi_a_reg;
    logic [CW-1:0]        semi_b_reg;
    logic [AW-1:0]        aa_reg;
    logic [AW-1:0]        bb_reg;
    logic [XW-1:0]        pt_x_reg;
    logic signed [YW-1:0] pt_y_reg;
    logic [XW-1:0]        hold_x_reg;
    logic signed [YW-1:0] hold_y_reg;
    logic signed [SW-1:0] sx_reg;
    logic signed [SW-1:0] sy_reg;
    logic signed [DW-1:0] dec_reg;
    logic signed [DW-1:0] dec_next;
    logic                 use_sx_reg;
    logic                 use_sy_reg;
    logic                 use_bb_reg;
    logic                 use_aa_reg;
    logic                 r2_reg;
    logic                 running_reg;
    logic [PW-1:0]        prod_reg;
    logic                 out_valid_reg;
    pix_t                 out_reg;

    // Datapath nets
    logic [XW:0]          tx;
    logic signed [YW-1:0] ty_s;
    logic [YW-1:0]        ty_mag;
    logic [MW-1:0]        mul_a;
    logic [MW-1:0]        mul_b;
    logic [PW-1:0]        prod_next;
    logic signed [DW-1:0] p_d;
    logic signed [DW-1:0] aa_d;
    logic signed [DW-1:0] bb_d;
    logic signed [DW-1:0] step_sum;
    logic signed [SW-1:0] aa2_s;
    logic signed [SW-1:0] bb2_s;
    logic                 dec_neg;
    logic                 dec_pos;
    logic                 step_x;
    logic                 step_y;
    logic [XW-1:0]        px_e;
    logic signed [YW-1:0] py_e;
    logic signed [PIX_W-1:0] cx12;
    logic signed [PIX_W-1:0] cy12;
    logic signed [PIX_W-1:0] px12;
    logic signed [PIX_W-1:0] py12;
    logic                 last_now;
    logic                 done_now;
    pix_t                 pix_next;

    // Request decode
    assign launch_start = start && !busy && !req.action;
    assign launch       = start && !busy && (!req.action || running_reg);
    assign launch_pc    = req.action ? PC_SP0 : PC_ST0;
    assign enter_r2     = !r2_reg && (sx_reg >= sy_reg);

    mer_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (launch),
        .launch_pc (launch_pc),
        .enter_r2  (enter_r2),
        .busy      (busy),
        .cw        (ctl)
    );

    // Multiplier operands
    assign tx     = {pt_x_reg, 1'b1};
    assign ty_s   = pt_y_reg - YW'(1);
    assign ty_mag = ty_s[YW-1] ? YW'(-ty_s) : YW'(ty_s);

    always_comb
    begin
        case (ctl.mul_a)
            MS_SEMI_A: mul_a = MW'(semi_a_reg);
            MS_SEMI_B: mul_a = MW'(semi_b_reg);
            MS_AA:     mul_a = MW'(aa_reg);
            MS_BB:     mul_a = MW'(bb_reg);
            MS_TX:     mul_a = MW'(tx);
            MS_TY:     mul_a = MW'(ty_mag);
            MS_PROD:   mul_a = prod_reg[MW-1:0];
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.mul_b)
            MS_SEMI_A: mul_b = MW'(semi_a_reg);
            MS_SEMI_B: mul_b = MW'(semi_b_reg);
            MS_AA:     mul_b = MW'(aa_reg);
            MS_BB:     mul_b = MW'(bb_reg);
            MS_TX:     mul_b = MW'(tx);
            MS_TY:     mul_b = MW'(ty_mag);
            MS_PROD:   mul_b = prod_reg[MW-1:0];
            default:   mul_b = '0;
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // Point step choice
    assign dec_neg = dec_reg[DW-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);
    assign step_x  = r2_reg ? !dec_pos : 1'b1;
    assign step_y  = r2_reg ? 1'b1 : !dec_neg;
    assign aa2_s   = signed'(SW'({aa_reg, 1'b0}));
    assign bb2_s   = signed'(SW'({bb_reg, 1'b0}));

    // Decision arithmetic, all terms scaled by 4
    assign p_d  = signed'(DW'(prod_reg));
    assign aa_d = signed'(DW'(aa_reg));
    assign bb_d = signed'(DW'(bb_reg));

    always_comb
    begin
        step_sum = (use_sx_reg ? DW'(sx_reg) : '0)
                 - (use_sy_reg ? DW'(sy_reg) : '0)
                 + (use_bb_reg ? bb_d : '0)
                 + (use_aa_reg ? aa_d : '0);
        case (ctl.dec_op)
            DEC_INIT: dec_next = (bb_d <<< 2) + aa_d - (p_d <<< 2);
            DEC_STEP: dec_next = dec_reg + (step_sum <<< 2);
            DEC_LOAD: dec_next = p_d;
            DEC_ADD4: dec_next = dec_reg + (p_d <<< 2);
            DEC_SUB4: dec_next = dec_reg - (p_d <<< 2);
            default:  dec_next = dec_reg;
        endcase
    end

    // Mirrored pixel for this cycle
    assign px_e     = ctl.pt_adv ? pt_x_reg : hold_x_reg;
    assign py_e     = ctl.pt_adv ? pt_y_reg : hold_y_reg;
    assign cx12     = signed'(PIX_W'(ctr_x_reg));
    assign cy12     = signed'(PIX_W'(ctr_y_reg));
    assign px12     = signed'(PIX_W'(px_e));
    assign py12     = PIX_W'(py_e);
    assign last_now = ctl.emit && (ctl.quad == QUAD_MM);
    assign done_now = last_now && r2_reg && pt_y_reg[YW-1];

    always_comb
    begin
        pix_next.pixel_x      = cx12 + (ctl.quad[1] ? -px12 : px12);
        pix_next.pixel_y      = cy12 + (ctl.quad[0] ? -py12 : py12);
        pix_next.last_of_step = last_now;
        pix_next.ellipse_done = done_now;
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            r2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctl.emit;
            if (launch_start)
            begin
                running_reg <= 1'b1;
            end
            else if (done_now)
            begin
                running_reg <= 1'b0;
            end
            if (launch_start)
            begin
                r2_reg <= 1'b0;
            end
            else if (ctl.set_r2)
            begin
                r2_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dec_reg  <= dec_next;
        if (ctl.emit)
        begin
            out_reg <= pix_next;
        end
        if (ctl.ld_aa)
        begin
            aa_reg <= prod_reg[AW-1:0];
        end
        if (ctl.ld_bb)
        begin
            bb_reg <= prod_reg[AW-1:0];
        end
        if (launch_start)
        begin
            ctr_x_reg  <= req.center_x[CW-1:0];
            ctr_y_reg  <= req.center_y[CW-1:0];
            semi_a_reg <= req.radius_x[CW-1:0];
            semi_b_reg <= req.radius_y[CW-1:0];
            pt_x_reg   <= '0;
            pt_y_reg   <= signed'(YW'(req.radius_y[CW-1:0]));
            sx_reg     <= '0;
        end
        else if (ctl.pt_adv)
        begin
            hold_x_reg <= pt_x_reg;
            hold_y_reg <= pt_y_reg;
            use_sx_reg <= step_x;
            use_sy_reg <= step_y;
            use_bb_reg <= !r2_reg || !step_x;
            use_aa_reg <= r2_reg && step_x;
            if (step_x)
            begin
                pt_x_reg <= XW'(pt_x_reg + 1'b1);
                sx_reg   <= sx_reg + bb2_s;
            end
            if (step_y)
            begin
                pt_y_reg <= pt_y_reg - YW'(1);
                sy_reg   <= sy_reg - aa2_s;
            end
        end
        if (ctl.ld_sy)
        begin
            sy_reg <= signed'({prod_reg[SW-2:0], 1'b0});
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    `MER_ASSERT_NEXT(a_launch_busy, launch, busy, "accepted request did not raise busy")
    `MER_ASSERT_NOW(a_last_fourth, result_valid && result.last_of_step,
        $past(result_valid, 3), "last pixel not preceded by three pixels")
    `MER_ASSERT_NOW(a_done_stops, result_valid && result.ellipse_done, !running_reg,
        "ellipse still running after its final pixel")
    `MER_ASSERT_NOW(a_r2_clear, $fell(r2_reg), $past(launch_start),
        "region flag cleared without a start request")

endmodule
